// ----- hdl/lc2k_pkg.sv -----
// Shared types, constants and command/status structs of the LC-2K instruction step block.
package lc2k_pkg;

	localparam int unsigned MEM_WORDS_DEF = 65536;
	localparam int unsigned NUM_REGS      = 8;
	localparam int unsigned WORD_W        = 32;
	localparam int unsigned ADDR_W        = 16;
	localparam int unsigned STATUS_W      = 3;
	localparam int unsigned COUNT_W       = 16;
	localparam int unsigned REG_IDX_W     = 3;
	localparam int unsigned OPCODE_W      = 3;
	localparam int unsigned OFFSET_W      = 16;

	// Instruction word field positions.
	localparam int unsigned OPC_LSB  = 22;
	localparam int unsigned RA_LSB   = 19;
	localparam int unsigned RB_LSB   = 16;
	localparam int unsigned DEST_LSB = 0;

	localparam logic [COUNT_W-1:0] STEP_LIMIT_RESET = 16'd1000;

	typedef enum logic [1:0] {
		OP_MEM_WRITE,
		OP_EXECUTE,
		OP_MEM_READ,
		OP_REG_READ
	} item_op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_DONE,
		ST_HALT,
		ST_LIMIT,
		ST_STOPPED,
		ST_READ
	} status_t;

	typedef enum logic [OPCODE_W-1:0] {
		OPC_ADD,
		OPC_NOR,
		OPC_LW,
		OPC_SW,
		OPC_BEQ,
		OPC_JALR,
		OPC_HALT,
		OPC_NOOP
	} opcode_t;

	typedef enum logic [1:0] {
		WS_IN_ADDR,
		WS_DATA_ADDR,
		WS_NEXT_PC,
		WS_PC_INC
	} wrap_sel_t;

	typedef enum logic [1:0] {
		MA_CLEAR,
		MA_PC,
		MA_WRAP
	} mem_addr_sel_t;

	typedef enum logic [1:0] {
		MW_ZERO,
		MW_ITEM,
		MW_REG
	} mem_wdata_sel_t;

	typedef struct packed {
		logic           in_ready;
		logic           item_take;
		logic           mem_clear;
		logic           mem_rd;
		logic           mem_wr;
		mem_addr_sel_t  ma_sel;
		mem_wdata_sel_t mw_sel;
		logic           wrap_start;
		wrap_sel_t      wrap_sel;
		logic           rf_rd_item;
		logic           rf_rd_insn;
		logic           rf_wr_exec;
		logic           rf_wr_load;
		logic           cap_mem;
		logic           cap_reg;
		logic           exec_finish;
		logic           out_load;
	} lc2k_cmd_t;

	typedef struct packed {
		logic     in_valid;
		item_op_t in_op;
		logic     stopped;
		logic     clear_last;
		logic     wrap_done;
		opcode_t  opcode;
		logic     out_free;
	} lc2k_stat_t;

endpackage

// ----- hdl/lc2k_if.sv -----
// Valid/ready channel interfaces for input items and result items.
interface lc2k_in_if;
	import lc2k_pkg::*;

	logic                     valid;
	logic                     ready;
	logic [1:0]               op;
	logic [ADDR_W-1:0]        addr;
	logic signed [WORD_W-1:0] data;

	modport source(output valid, output op, output addr, output data, input ready);
	modport sink(input valid, input op, input addr, input data, output ready);
endinterface

interface lc2k_out_if;
	import lc2k_pkg::*;

	logic                     valid;
	logic                     ready;
	logic [STATUS_W-1:0]      status;
	logic [ADDR_W-1:0]        pc_value;
	logic signed [WORD_W-1:0] read_data;
	logic [COUNT_W-1:0]       executed;

	modport source(output valid, output status, output pc_value, output read_data,
		output executed, input ready);
	modport sink(input valid, input status, input pc_value, input read_data,
		input executed, output ready);
endinterface

// ----- hdl/lc2k_instruction_step.sv -----
// Top level of the LC-2K instruction step block: controller, datapath and checks.
// LC-2K word machine that takes one item at a time on a valid/ready channel and
// returns exactly one result item for each: a memory word write, one executed
// instruction, a memory word read or a register read. After reset the block first
// sweeps the word memory to zero, one word per cycle, and takes no item until that
// pass ends; step_limit may be written at any time the block is idle. How long an
// item occupies the block, from accept to the result being offered, depends on its
// kind and opcode: the fetch and the data access take turns on the single-port word
// memory, and every item address, data address and next pc passes through one
// shared reduction unit. With a power-of-two MEM_WORDS that unit is a registered
// mask; with any other MEM_WORDS it estimates the quotient by a reciprocal
// multiplication and corrects it once, which adds registered stages to each address
// reduction (one reduction for memory items and most instructions, two for lw and
// sw). A new item is accepted while the previous result still waits to be taken.
module lc2k_instruction_step #(
	parameter int unsigned MEM_WORDS = lc2k_pkg::MEM_WORDS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [lc2k_pkg::COUNT_W-1:0] cfg_wdata,
	lc2k_in_if.sink                      item_in,
	lc2k_out_if.source                   result_out
);
	import lc2k_pkg::*;

	lc2k_cmd_t  cmd;
	lc2k_stat_t stat;

	lc2k_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.stat  (stat),
		.cmd   (cmd)
	);

	lc2k_datapath #(
		.MEM_WORDS(MEM_WORDS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.item_in   (item_in),
		.result_out(result_out),
		.cmd       (cmd),
		.stat      (stat)
	);

	// Items are worked one at a time, so ready drops right after an accept.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(item_in.valid && item_in.ready) |=> !item_in.ready)
		else $error("item accepted while another item is in progress");

	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mem_clear |-> !item_in.ready)
		else $error("input ready during the memory clearing pass");

	a_result_offered: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> result_out.valid)
		else $error("loaded result item not offered");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.out_load && result_out.valid) |-> result_out.ready)
		else $error("result item overwritten before it was taken");

endmodule

// ----- hdl/lc2k_addr_wrap.sv -----
// Reduces a 32-bit address modulo the memory size: a mask for powers of two, else a reciprocal.
module lc2k_addr_wrap #(
	parameter int unsigned MEM_WORDS = lc2k_pkg::MEM_WORDS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic [lc2k_pkg::WORD_W-1:0]         operand,
	output logic                                done,
	output logic [$clog2(MEM_WORDS)-1:0]        result
);
	import lc2k_pkg::*;

	localparam int unsigned AW   = $clog2(MEM_WORDS);
	localparam bit          POW2 = (MEM_WORDS & (MEM_WORDS - 1)) == 0;

	generate
		if (POW2) begin : g_mask
			logic          done_q;
			logic [AW-1:0] res_q;

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					done_q <= 1'b0;
				end else begin
					done_q <= start;
				end
			end

			always_ff @(posedge clk) begin
				if (start) begin
					res_q <= operand[AW-1:0];
				end
			end

			assign done   = done_q;
			assign result = res_q;
		end else begin : g_recip
			// The reciprocal estimate of the quotient is low by at most one, so a
			// single compare and subtract finishes the remainder.
			localparam logic [WORD_W-1:0] RECIP = WORD_W'((64'd1 << WORD_W) / MEM_WORDS);

			logic [2:0]          stage_q;
			logic                done_q;
			logic [WORD_W-1:0]   val_q;
			logic [WORD_W-1:0]   quot_q;
			logic [AW:0]         rem_est_q;
			logic [AW-1:0]       res_q;
			logic [2*WORD_W-1:0] prod;
			logic [WORD_W-1:0]   back;

			assign prod = (2 * WORD_W)'(val_q) * (2 * WORD_W)'(RECIP);
			assign back = val_q - quot_q * WORD_W'(MEM_WORDS);

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					stage_q <= '0;
					done_q  <= 1'b0;
				end else begin
					stage_q <= {stage_q[1:0], start};
					done_q  <= stage_q[2];
				end
			end

			always_ff @(posedge clk) begin
				if (start) begin
					val_q <= operand;
				end
				if (stage_q[0]) begin
					quot_q <= prod[2*WORD_W-1:WORD_W];
				end
				if (stage_q[1]) begin
					rem_est_q <= back[AW:0];
				end
				if (stage_q[2]) begin
					if (rem_est_q >= (AW + 1)'(MEM_WORDS)) begin
						res_q <= AW'(rem_est_q - (AW + 1)'(MEM_WORDS));
					end else begin
						res_q <= rem_est_q[AW-1:0];
					end
				end
			end

			assign done   = done_q;
			assign result = res_q;
		end
	endgenerate

endmodule

// ----- hdl/lc2k_datapath.sv -----
// Datapath: word memory, register file, program counter, step counter and result register.
module lc2k_datapath #(
	parameter int unsigned MEM_WORDS = lc2k_pkg::MEM_WORDS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [lc2k_pkg::COUNT_W-1:0]     cfg_wdata,
	lc2k_in_if.sink                          item_in,
	lc2k_out_if.source                       result_out,
	input  lc2k_pkg::lc2k_cmd_t              cmd,
	output lc2k_pkg::lc2k_stat_t             stat
);
	import lc2k_pkg::*;

	localparam int unsigned AW = $clog2(MEM_WORDS);

	logic [COUNT_W-1:0]  step_limit_q;
	logic [COUNT_W-1:0]  step_count_q;
	logic                stopped_q;
	logic [AW-1:0]       pc_q;
	logic [AW-1:0]       clr_q;

	logic [WORD_W-1:0]   data_q;
	logic [WORD_W-1:0]   mem_rd_q;
	logic [WORD_W-1:0]   insn_q;
	logic [WORD_W-1:0]   rfa_q;
	logic [WORD_W-1:0]   rfb_q;
	status_t             res_status_q;
	logic [WORD_W-1:0]   res_data_q;

	logic                out_valid_q;
	status_t             out_status_q;
	logic [ADDR_W-1:0]   out_pc_q;
	logic [WORD_W-1:0]   out_data_q;
	logic [COUNT_W-1:0]  out_count_q;

	logic [WORD_W-1:0]   mem [MEM_WORDS];
	logic [WORD_W-1:0]   rf_mem [NUM_REGS];
	logic [NUM_REGS-1:0] rf_valid_q;

	// Decoded fields of the current instruction.
	opcode_t             opc;
	logic [REG_IDX_W-1:0] ra;
	logic [REG_IDX_W-1:0] rb;
	logic [REG_IDX_W-1:0] rd;
	logic [WORD_W-1:0]   off;
	logic [WORD_W-1:0]   pc_ext;
	logic [WORD_W-1:0]   pc_inc;
	logic [WORD_W-1:0]   next_pc;
	logic [WORD_W-1:0]   data_addr;

	logic [WORD_W-1:0]   wrap_operand;
	logic                wrap_done;
	logic [AW-1:0]       wrap_res;

	logic [AW-1:0]       mem_addr;
	logic [WORD_W-1:0]   mem_wdata;
	logic                mem_we;

	logic                rf_rd;
	logic [REG_IDX_W-1:0] rf_ra;
	logic [REG_IDX_W-1:0] rf_rb;
	logic                rf_we;
	logic [REG_IDX_W-1:0] rf_waddr;
	logic [WORD_W-1:0]   rf_wdata;

	logic [COUNT_W-1:0]  count_next;
	logic                out_free;

	assign opc       = opcode_t'(insn_q[OPC_LSB +: OPCODE_W]);
	assign ra        = insn_q[RA_LSB +: REG_IDX_W];
	assign rb        = insn_q[RB_LSB +: REG_IDX_W];
	assign rd        = insn_q[DEST_LSB +: REG_IDX_W];
	assign off       = {{(WORD_W - OFFSET_W){insn_q[OFFSET_W-1]}}, insn_q[OFFSET_W-1:0]};
	assign pc_ext    = WORD_W'(pc_q);
	assign pc_inc    = pc_ext + 1'b1;
	assign data_addr = rfa_q + off;

	always_comb begin
		unique case (opc)
			OPC_BEQ: begin
				next_pc = (rfa_q == rfb_q) ? pc_inc + off : pc_inc;
			end
			// The link write lands first, so equal register numbers read back pc+1.
			OPC_JALR: begin
				next_pc = (ra == rb) ? pc_inc : rfa_q;
			end
			default: begin
				next_pc = pc_inc;
			end
		endcase
	end

	always_comb begin
		unique case (cmd.wrap_sel)
			WS_IN_ADDR:   wrap_operand = WORD_W'(item_in.addr);
			WS_DATA_ADDR: wrap_operand = data_addr;
			WS_NEXT_PC:   wrap_operand = next_pc;
			WS_PC_INC:    wrap_operand = pc_inc;
			default:      wrap_operand = pc_inc;
		endcase
	end

	lc2k_addr_wrap #(
		.MEM_WORDS(MEM_WORDS)
	) u_wrap (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.wrap_start),
		.operand(wrap_operand),
		.done   (wrap_done),
		.result (wrap_res)
	);

	// Word memory, single port.
	always_comb begin
		unique case (cmd.ma_sel)
			MA_CLEAR: mem_addr = clr_q;
			MA_PC:    mem_addr = pc_q;
			MA_WRAP:  mem_addr = wrap_res;
			default:  mem_addr = wrap_res;
		endcase
		unique case (cmd.mw_sel)
			MW_ZERO: mem_wdata = '0;
			MW_ITEM: mem_wdata = data_q;
			MW_REG:  mem_wdata = rfb_q;
			default: mem_wdata = '0;
		endcase
	end

	assign mem_we = cmd.mem_wr | cmd.mem_clear;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_addr] <= mem_wdata;
		end
		if (cmd.mem_rd) begin
			mem_rd_q <= mem[mem_addr];
		end
	end

	// Register file: two registered read ports, one write port.
	assign rf_rd = cmd.rf_rd_item | cmd.rf_rd_insn;
	assign rf_ra = cmd.rf_rd_item ? item_in.addr[REG_IDX_W-1:0]
		: mem_rd_q[RA_LSB +: REG_IDX_W];
	assign rf_rb = mem_rd_q[RB_LSB +: REG_IDX_W];

	always_comb begin
		rf_we    = 1'b0;
		rf_waddr = rd;
		rf_wdata = rfa_q + rfb_q;
		if (cmd.rf_wr_load) begin
			rf_we    = 1'b1;
			rf_waddr = rb;
			rf_wdata = mem_rd_q;
		end else if (cmd.rf_wr_exec) begin
			unique case (opc)
				OPC_ADD: begin
					rf_we = 1'b1;
				end
				OPC_NOR: begin
					rf_we    = 1'b1;
					rf_wdata = ~(rfa_q | rfb_q);
				end
				OPC_JALR: begin
					rf_we    = 1'b1;
					rf_waddr = rb;
					rf_wdata = pc_inc;
				end
				default: begin
					rf_we = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (rf_we) begin
			rf_mem[rf_waddr] <= rf_wdata;
		end
		if (rf_rd) begin
			rfa_q <= rf_valid_q[rf_ra] ? rf_mem[rf_ra] : '0;
			rfb_q <= rf_valid_q[rf_rb] ? rf_mem[rf_rb] : '0;
		end
	end

	assign count_next = (step_count_q != '1) ? step_count_q + 1'b1 : step_count_q;
	assign out_free   = !out_valid_q || result_out.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_limit_q <= STEP_LIMIT_RESET;
			step_count_q <= '0;
			stopped_q    <= 1'b0;
			pc_q         <= '0;
			clr_q        <= '0;
			rf_valid_q   <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				step_limit_q <= cfg_wdata;
			end
			if (cmd.mem_clear) begin
				clr_q <= clr_q + 1'b1;
			end
			if (rf_we) begin
				rf_valid_q[rf_waddr] <= 1'b1;
			end
			if (cmd.exec_finish) begin
				pc_q         <= wrap_res;
				step_count_q <= count_next;
				if (opc == OPC_HALT || count_next >= step_limit_q) begin
					stopped_q <= 1'b1;
				end
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (result_out.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.item_take) begin
			data_q     <= item_in.data;
			res_data_q <= '0;
			unique case (item_op_t'(item_in.op))
				OP_MEM_WRITE: res_status_q <= ST_DONE;
				OP_EXECUTE:   res_status_q <= stopped_q ? ST_STOPPED : ST_DONE;
				OP_MEM_READ:  res_status_q <= ST_READ;
				OP_REG_READ:  res_status_q <= ST_READ;
				default:      res_status_q <= ST_READ;
			endcase
		end
		if (cmd.cap_mem) begin
			res_data_q <= mem_rd_q;
		end
		if (cmd.cap_reg) begin
			res_data_q <= rfa_q;
		end
		if (cmd.rf_rd_insn) begin
			insn_q <= mem_rd_q;
		end
		// A halt reports as halt even when it is also the last allowed step.
		if (cmd.exec_finish) begin
			if (opc == OPC_HALT) begin
				res_status_q <= ST_HALT;
			end else if (count_next >= step_limit_q) begin
				res_status_q <= ST_LIMIT;
			end
		end
		if (cmd.out_load) begin
			out_status_q <= res_status_q;
			out_pc_q     <= ADDR_W'(pc_q);
			out_data_q   <= res_data_q;
			out_count_q  <= step_count_q;
		end
	end

	assign item_in.ready        = cmd.in_ready;
	assign result_out.valid     = out_valid_q;
	assign result_out.status    = out_status_q;
	assign result_out.pc_value  = out_pc_q;
	assign result_out.read_data = out_data_q;
	assign result_out.executed  = out_count_q;

	assign stat.in_valid   = item_in.valid;
	assign stat.in_op      = item_op_t'(item_in.op);
	assign stat.stopped    = stopped_q;
	assign stat.clear_last = (clr_q == AW'(MEM_WORDS - 1));
	assign stat.wrap_done  = wrap_done;
	assign stat.opcode     = opc;
	assign stat.out_free   = out_free;

endmodule

// ----- hdl/lc2k_ctrl.sv -----
// Controller state machine that sequences the clearing pass, memory items and instruction steps.
module lc2k_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  lc2k_pkg::lc2k_stat_t  stat,
	output lc2k_pkg::lc2k_cmd_t   cmd
);
	import lc2k_pkg::*;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_WR_WAIT,
		S_RD_WAIT,
		S_CAP_MEM,
		S_CAP_REG,
		S_DECODE,
		S_EXEC,
		S_DATA_WAIT,
		S_MEM_WB,
		S_PC_WAIT,
		S_RESP
	} state_t;

	state_t state_q;
	state_t state_next;

	always_comb begin
		cmd        = '0;
		state_next = state_q;
		unique case (state_q)
			S_CLEAR: begin
				cmd.mem_clear = 1'b1;
				cmd.ma_sel    = MA_CLEAR;
				cmd.mw_sel    = MW_ZERO;
				if (stat.clear_last) begin
					state_next = S_IDLE;
				end
			end
			S_IDLE: begin
				cmd.in_ready = 1'b1;
				if (stat.in_valid) begin
					cmd.item_take = 1'b1;
					unique case (stat.in_op)
						OP_MEM_WRITE: begin
							cmd.wrap_start = 1'b1;
							cmd.wrap_sel   = WS_IN_ADDR;
							state_next     = S_WR_WAIT;
						end
						OP_MEM_READ: begin
							cmd.wrap_start = 1'b1;
							cmd.wrap_sel   = WS_IN_ADDR;
							state_next     = S_RD_WAIT;
						end
						OP_REG_READ: begin
							cmd.rf_rd_item = 1'b1;
							state_next     = S_CAP_REG;
						end
						OP_EXECUTE: begin
							if (stat.stopped) begin
								state_next = S_RESP;
							end else begin
								// Instruction fetch overlaps the accept cycle.
								cmd.mem_rd = 1'b1;
								cmd.ma_sel = MA_PC;
								state_next = S_DECODE;
							end
						end
						default: begin
							state_next = S_RESP;
						end
					endcase
				end
			end
			S_WR_WAIT: begin
				if (stat.wrap_done) begin
					cmd.mem_wr = 1'b1;
					cmd.ma_sel = MA_WRAP;
					cmd.mw_sel = MW_ITEM;
					state_next = S_RESP;
				end
			end
			S_RD_WAIT: begin
				if (stat.wrap_done) begin
					cmd.mem_rd = 1'b1;
					cmd.ma_sel = MA_WRAP;
					state_next = S_CAP_MEM;
				end
			end
			S_CAP_MEM: begin
				cmd.cap_mem = 1'b1;
				state_next  = S_RESP;
			end
			S_CAP_REG: begin
				cmd.cap_reg = 1'b1;
				state_next  = S_RESP;
			end
			S_DECODE: begin
				cmd.rf_rd_insn = 1'b1;
				state_next     = S_EXEC;
			end
			S_EXEC: begin
				cmd.wrap_start = 1'b1;
				if (stat.opcode == OPC_LW || stat.opcode == OPC_SW) begin
					cmd.wrap_sel = WS_DATA_ADDR;
					state_next   = S_DATA_WAIT;
				end else begin
					cmd.rf_wr_exec = 1'b1;
					cmd.wrap_sel   = WS_NEXT_PC;
					state_next     = S_PC_WAIT;
				end
			end
			S_DATA_WAIT: begin
				if (stat.wrap_done) begin
					cmd.ma_sel = MA_WRAP;
					if (stat.opcode == OPC_SW) begin
						cmd.mem_wr = 1'b1;
						cmd.mw_sel = MW_REG;
					end else begin
						cmd.mem_rd = 1'b1;
					end
					state_next = S_MEM_WB;
				end
			end
			S_MEM_WB: begin
				cmd.wrap_start = 1'b1;
				cmd.wrap_sel   = WS_PC_INC;
				cmd.rf_wr_load = (stat.opcode == OPC_LW);
				state_next     = S_PC_WAIT;
			end
			S_PC_WAIT: begin
				if (stat.wrap_done) begin
					cmd.exec_finish = 1'b1;
					state_next      = S_RESP;
				end
			end
			S_RESP: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					state_next   = S_IDLE;
				end
			end
			default: begin
				state_next = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_next;
		end
	end

endmodule

// ----- bench/lc2k_instruction_step_tb.sv -----
// Self-checking testbench for the LC-2K instruction step block with a shadow machine.
`timescale 1ns / 1ps

module lc2k_instruction_step_tb;
	import lc2k_pkg::*;

	localparam int unsigned CLK_HALF      = 6;
	localparam int unsigned RESET_CYCLES  = 7;
	localparam int unsigned HOLD_CYCLES   = 300;
	localparam int unsigned SETTLE_CYCLES = 40;
	localparam int unsigned MAX_PRINTED   = 40;

	typedef struct {
		status_t             status;
		logic [ADDR_W-1:0]   pc_value;
		logic [WORD_W-1:0]   read_data;
		logic [COUNT_W-1:0]  executed;
	} reply_t;

	// Shadow copy of the machine plus the queue of replies it still owes.
	class lc2k_shadow;
		bit [WORD_W-1:0]    shadow_mem [MEM_WORDS_DEF];
		bit [WORD_W-1:0]    shadow_regs [NUM_REGS];
		bit [WORD_W-1:0]    shadow_pc;
		bit                 shadow_stopped;
		bit [COUNT_W-1:0]   shadow_count;
		bit [COUNT_W-1:0]   shadow_limit;
		reply_t             awaited_replies [$];
		int unsigned        mismatches;
		int unsigned        replies_checked;
		int unsigned        op_counts [4];
		int unsigned        status_counts [8];

		function new();
			shadow_limit = STEP_LIMIT_RESET;
		endfunction

		function bit [WORD_W-1:0] word_index(bit [WORD_W-1:0] a);
			return a % MEM_WORDS_DEF;
		endfunction

		function void note_item(item_op_t op, logic [ADDR_W-1:0] addr, logic [WORD_W-1:0] data);
			reply_t              r;
			bit [WORD_W-1:0]     insn;
			bit [WORD_W-1:0]     off;
			bit [WORD_W-1:0]     next_pc;
			bit [REG_IDX_W-1:0]  ra;
			bit [REG_IDX_W-1:0]  rb;
			bit [REG_IDX_W-1:0]  rd;
			opcode_t             opc;
			bit                  halted;
			r.status = ST_DONE;
			r.read_data = '0;
			halted = 1'b0;
			op_counts[op]++;
			case (op)
				OP_MEM_WRITE: begin
					shadow_mem[word_index(addr)] = data;
				end
				OP_EXECUTE: begin
					if (shadow_stopped) begin
						r.status = ST_STOPPED;
					end else begin
						insn = shadow_mem[word_index(shadow_pc)];
						opc = opcode_t'(insn[OPC_LSB +: OPCODE_W]);
						ra = insn[RA_LSB +: REG_IDX_W];
						rb = insn[RB_LSB +: REG_IDX_W];
						rd = insn[DEST_LSB +: REG_IDX_W];
						off = {{(WORD_W-OFFSET_W){insn[OFFSET_W-1]}}, insn[OFFSET_W-1:0]};
						next_pc = shadow_pc + 1;
						case (opc)
							OPC_ADD: shadow_regs[rd] = shadow_regs[ra] + shadow_regs[rb];
							OPC_NOR: shadow_regs[rd] = ~(shadow_regs[ra] | shadow_regs[rb]);
							OPC_LW: shadow_regs[rb] = shadow_mem[word_index(shadow_regs[ra] + off)];
							OPC_SW: shadow_mem[word_index(shadow_regs[ra] + off)] = shadow_regs[rb];
							OPC_BEQ: begin
								if (shadow_regs[ra] == shadow_regs[rb])
									next_pc = shadow_pc + off + 1;
							end
							OPC_JALR: begin
								// The link is written first, so regA equal to regB falls through.
								shadow_regs[rb] = shadow_pc + 1;
								next_pc = shadow_regs[ra];
							end
							OPC_HALT: halted = 1'b1;
							default: ;
						endcase
						shadow_pc = word_index(next_pc);
						if (shadow_count != {COUNT_W{1'b1}})
							shadow_count++;
						if (halted) begin
							shadow_stopped = 1'b1;
							r.status = ST_HALT;
						end else if (shadow_count >= shadow_limit) begin
							shadow_stopped = 1'b1;
							r.status = ST_LIMIT;
						end
					end
				end
				OP_MEM_READ: begin
					r.read_data = shadow_mem[word_index(addr)];
					r.status = ST_READ;
				end
				default: begin
					r.read_data = shadow_regs[addr[REG_IDX_W-1:0]];
					r.status = ST_READ;
				end
			endcase
			r.pc_value = shadow_pc[ADDR_W-1:0];
			r.executed = shadow_count;
			awaited_replies.push_back(r);
		endfunction

		task report(string what);
			mismatches++;
			if (mismatches <= MAX_PRINTED)
				$display("%0t ns: mismatch at result %0d: %s", $time, replies_checked, what);
		endtask

		task check_result(logic [STATUS_W-1:0] status, logic [ADDR_W-1:0] pc_value,
			logic [WORD_W-1:0] read_data, logic [COUNT_W-1:0] executed);
			reply_t awaited;
			if (awaited_replies.size() == 0) begin
				report($sformatf("result with none awaited (status %0d pc %0d)", status, pc_value));
				return;
			end
			awaited = awaited_replies.pop_front();
			replies_checked++;
			status_counts[awaited.status]++;
			if (status !== awaited.status)
				report($sformatf("status %0d, awaited %s", status, awaited.status.name()));
			if (pc_value !== awaited.pc_value)
				report($sformatf("pc_value %0d, awaited %0d", pc_value, awaited.pc_value));
			if (read_data !== awaited.read_data)
				report($sformatf("read_data %h, awaited %h", read_data, awaited.read_data));
			if (executed !== awaited.executed)
				report($sformatf("executed %0d, awaited %0d", executed, awaited.executed));
		endtask
	endclass

	logic                clk = 1'b0;
	logic                arst_n;
	logic                cfg_we;
	logic [COUNT_W-1:0]  cfg_wdata;

	lc2k_in_if  item_if ();
	lc2k_out_if result_if ();

	lc2k_instruction_step dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.item_in    (item_if),
		.result_out (result_if)
	);

	lc2k_shadow   board;
	bit           idle_on = 1'b1;
	bit           hold_results = 1'b0;
	int unsigned  items_sent = 0;
	int unsigned  limits_written = 0;
	string        ending_desc [4] = '{"a halt on the last allowed step", "a plain halt",
		"a limit lowered below the count", "reaching the limit exactly"};

	always #(CLK_HALF) clk = ~clk;

	function automatic int unsigned pick_gap();
		int unsigned roll;
		if (!idle_on)
			return 0;
		roll = $urandom_range(0, 99);
		if (roll < 55)
			return 0;
		if (roll < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [WORD_W-1:0] encode_insn(opcode_t opc, logic [2:0] ra, logic [2:0] rb,
		logic [OFFSET_W-1:0] low);
		logic [WORD_W-1:0] w;
		w = '0;
		w[OPC_LSB +: OPCODE_W] = opc;
		w[RA_LSB +: REG_IDX_W] = ra;
		w[RB_LSB +: REG_IDX_W] = rb;
		w[OFFSET_W-1:0] = low;
		return w;
	endfunction

	// Any opcode but halt, so that random programs keep the machine running.
	function automatic logic [WORD_W-1:0] random_insn();
		logic [WORD_W-1:0] w;
		w = $urandom;
		w[OPC_LSB +: OPCODE_W] = OPCODE_W'($urandom_range(0, 6));
		if (w[OPC_LSB +: OPCODE_W] == OPC_HALT)
			w[OPC_LSB +: OPCODE_W] = OPC_NOOP;
		// Half the offsets stay near zero so branches land close by.
		if ($urandom_range(0, 1) == 1)
			w[OFFSET_W-1:0] = 16'($urandom_range(0, 16)) - 16'd8;
		return w;
	endfunction

	task automatic send_item(item_op_t op, logic [ADDR_W-1:0] addr, logic [WORD_W-1:0] data);
		int unsigned gap;
		gap = pick_gap();
		if (gap != 0) begin
			item_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_if.valid <= 1'b1;
		item_if.op <= op;
		item_if.addr <= addr;
		item_if.data <= data;
		do @(posedge clk); while (item_if.ready !== 1'b1);
		board.note_item(op, addr, data);
		items_sent++;
	endtask

	task automatic drain_results();
		item_if.valid <= 1'b0;
		while (board.awaited_replies.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_limit(logic [COUNT_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		board.shadow_limit = value;
		limits_written++;
	endtask

	task automatic random_phase(int unsigned quota);
		int unsigned        stop_at;
		int unsigned        burst;
		int unsigned        runs;
		int unsigned        i;
		logic [WORD_W-1:0]  base;
		logic [WORD_W-1:0]  w;
		item_op_t           op;
		stop_at = items_sent + quota;
		while (items_sent < stop_at) begin
			case ($urandom_range(0, 9))
				0, 1: begin
					op = item_op_t'($urandom_range(0, 3));
					w = $urandom;
					if (op == OP_MEM_WRITE && w[OPC_LSB +: OPCODE_W] == OPC_HALT &&
						$urandom_range(0, 7) != 0)
						w[OPC_LSB] = 1'b1;
					send_item(op, 16'($urandom), w);
				end
				2: begin
					if ($urandom_range(0, 1) == 1)
						send_item(OP_REG_READ, 16'($urandom), $urandom);
					else
						send_item(OP_MEM_READ, 16'($urandom), $urandom);
				end
				default: begin
					// A short program laid down at the current pc, then run.
					burst = $urandom_range(1, 8);
					base = board.shadow_pc;
					for (i = 0; i < burst; i++)
						send_item(OP_MEM_WRITE, 16'((base + i) % MEM_WORDS_DEF), random_insn());
					runs = ($urandom_range(0, 9) == 0) ? $urandom_range(0, burst + 2) : burst;
					for (i = 0; i < runs; i++) begin
						send_item(OP_EXECUTE, 16'($urandom), $urandom);
						if ($urandom_range(0, 4) == 0)
							send_item(OP_REG_READ, 16'($urandom), $urandom);
					end
				end
			endcase
		end
	endtask

	initial begin : result_side
		int unsigned stall;
		stall = 0;
		result_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (result_if.valid === 1'b1 && result_if.ready === 1'b1)
				board.check_result(result_if.status, result_if.pc_value, result_if.read_data,
					result_if.executed);
			if (hold_results) begin
				result_if.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_results = 1'b0;
			end else if (stall != 0) begin
				result_if.ready <= 1'b0;
				stall--;
			end else begin
				result_if.ready <= 1'b1;
				if ($urandom_range(0, 3) == 0)
					stall = pick_gap();
			end
		end
	end

	initial begin : stimulus
		int unsigned        ending;
		int unsigned        i;
		logic [WORD_W-1:0]  last_word;
		board = new();
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= '0;
		item_if.valid <= 1'b0;
		item_if.op <= OP_MEM_WRITE;
		item_if.addr <= '0;
		item_if.data <= '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// Directed program: every opcode but halt, address and pc wrap, jalr corner cases.
		send_item(OP_MEM_READ, 16'h0000, 32'h0000_0000);
		send_item(OP_MEM_READ, 16'hFFFF, 32'hFFFF_FFFF);
		send_item(OP_REG_READ, 16'hFFFF, 32'h8000_0000);
		send_item(OP_MEM_WRITE, 16'hFFFF, encode_insn(OPC_JALR, 3'd0, 3'd6, 16'h0000));
		send_item(OP_MEM_WRITE, 16'd0, encode_insn(OPC_NOR, 3'd0, 3'd0, 16'd1));
		send_item(OP_MEM_WRITE, 16'd1, encode_insn(OPC_ADD, 3'd1, 3'd1, 16'd2));
		send_item(OP_MEM_WRITE, 16'd2, encode_insn(OPC_LW, 3'd0, 3'd3, 16'hFFFF));
		send_item(OP_MEM_WRITE, 16'd3, encode_insn(OPC_SW, 3'd1, 3'd2, 16'h7FFF));
		send_item(OP_MEM_WRITE, 16'd4, encode_insn(OPC_BEQ, 3'd1, 3'd2, 16'd100));
		send_item(OP_MEM_WRITE, 16'd5, encode_insn(OPC_BEQ, 3'd0, 3'd0, 16'd1));
		send_item(OP_MEM_WRITE, 16'd7, encode_insn(OPC_JALR, 3'd4, 3'd4, 16'h8000));
		send_item(OP_MEM_WRITE, 16'd8, encode_insn(OPC_NOOP, 3'd7, 3'd7, 16'h7FFF));
		send_item(OP_MEM_WRITE, 16'd9, encode_insn(OPC_JALR, 3'd1, 3'd5, 16'h0000));
		repeat (11) send_item(OP_EXECUTE, 16'($urandom), $urandom);
		send_item(OP_MEM_READ, 16'h7FFE, 32'h7FFF_FFFF);
		send_item(OP_REG_READ, 16'hFFFE, 32'h0000_0000);

		drain_results();
		write_limit(16'hFFFF);
		random_phase(120);
		// The receiver stops taking results while items keep coming.
		hold_results = 1'b1;
		random_phase(130);

		drain_results();
		write_limit(16'(board.shadow_count + $urandom_range(400, 2000)));
		idle_on = 1'b0;
		random_phase(150);
		idle_on = 1'b1;

		drain_results();
		write_limit(16'(board.shadow_count + $urandom_range(200, 900)));
		random_phase(150);

		// The machine stops for good, so the seed picks how it ends.
		ending = $urandom_range(0, 3);
		drain_results();
		case (ending)
			0, 3: write_limit(16'(board.shadow_count + 1));
			2: write_limit(16'd1);
			default: ;
		endcase
		last_word = random_insn();
		if (ending <= 1)
			last_word[OPC_LSB +: OPCODE_W] = OPC_HALT;
		send_item(OP_MEM_WRITE, 16'(board.shadow_pc), last_word);
		send_item(OP_EXECUTE, 16'($urandom), $urandom);

		// Once stopped, execution is refused but memory and registers still answer.
		for (i = 0; i < 20; i++)
			send_item(item_op_t'($urandom_range(0, 3)), 16'($urandom), $urandom);
		drain_results();
		write_limit(16'd1);
		send_item(OP_EXECUTE, 16'($urandom), $urandom);
		send_item(OP_REG_READ, 16'($urandom), $urandom);

		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("Checked %0d results: %0d writes, %0d executes, %0d memory reads, %0d register reads.",
			board.replies_checked, board.op_counts[OP_MEM_WRITE], board.op_counts[OP_EXECUTE],
			board.op_counts[OP_MEM_READ], board.op_counts[OP_REG_READ]);
		$display("Ran %0d instructions over %0d step limits, ending on %s (%0d refused executes).",
			board.shadow_count, limits_written, ending_desc[ending],
			board.status_counts[ST_STOPPED]);
		if (board.mismatches == 0 && board.awaited_replies.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	initial begin : watchdog
		#10ms;
		$display("Run did not finish in time.");
		$display("*** FAILED ***");
		$finish;
	end

endmodule
